@@ rtl/core/drnd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package drnd_pkg;

   localparam int LimbWidth  = 32;
   localparam int LimbCount  = 6;
   localparam int WideWidth  = LimbWidth * LimbCount;
   localparam int NarrowWidth = LimbWidth * 3;
   localparam int ScaleWidth = 5;

   // Request word: the 192-bit coefficient in four pieces plus its scale.
   typedef struct packed {
      logic [31:0]           upper_high;
      logic [63:0]           upper_low;
      logic [31:0]           lower_high;
      logic [63:0]           lower_low;
      logic [ScaleWidth-1:0] scale_in;
   } req_type;

   // Response word: the rounded 96-bit mantissa, remaining scale and overflow.
   typedef struct packed {
      logic [31:0]           mantissa_high;
      logic [63:0]           mantissa_low;
      logic [ScaleWidth-1:0] scale_out;
      logic                  too_large;
   } rsp_type;

endpackage

`default_nettype wire

@@ rtl/core/decimal_round_192_to_96.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Narrows a 192-bit unsigned decimal coefficient to 96 bits. While the scale
// is nonzero and the value does not fit in 96 bits, the value is divided by
// ten and rounded half-to-even on the removed digit alone, and the scale drops
// by one. If the value fits in the end, the response carries the 96-bit
// mantissa and the scale reached; otherwise too_large is set, the mantissa
// carries the lower 96 input bits unchanged, and the scale is the one reached
// (zero). One request word is handled at a time and req_ready is low while it
// is in work. Each of the N divide steps taken (N <= scale_in, at most 31)
// runs one shared 36-bit divide-by-ten unit over the six 32-bit limbs, most
// significant first, then applies the rounding increment and the fit check.
// The finished response sits in an output register, so a new request is
// taken as soon as the previous result has been handed to it.

module decimal_round_192_to_96 (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire drnd_pkg::req_type req_data,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      drnd_pkg::rsp_type rsp_data
);

   import drnd_pkg::*;

   localparam logic [31:0] RecipTen = 32'hCCCC_CCCD;  // ceil(2^35 / 10)
   localparam int          CntWidth = $clog2(LimbCount);
   localparam logic [CntWidth-1:0] LastLimb = CntWidth'(LimbCount - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_ROUND,
      ST_FINISH
   } state_type;

   state_type                state_ff, state_in;
   logic [WideWidth-1:0]     value_ff, value_in;
   logic [NarrowWidth-1:0]   saved_ff, saved_in;
   logic [ScaleWidth-1:0]    scale_ff, scale_in;
   logic [3:0]               rem_ff, rem_in;
   logic [CntWidth-1:0]      cnt_ff, cnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   // Shared divide-by-ten unit: (remainder : top limb) / 10.
   logic [35:0]              div_num;
   logic [67:0]              div_prod;
   logic [32:0]              q_est;
   logic [36:0]              q_times_ten;
   logic [36:0]              div_diff;
   logic [31:0]              div_quot;
   logic [3:0]               div_rem;

   // Rounding and fit check.
   logic                     round_up;
   logic [WideWidth-1:0]     value_inc;
   logic [ScaleWidth-1:0]    scale_dec;
   logic                     value_big;
   logic                     inc_big;

   assign div_num     = {rem_ff, value_ff[WideWidth-1 -: LimbWidth]};
   assign div_prod    = div_num * RecipTen;
   // The estimate is the true quotient or one above it.
   assign q_est       = div_prod[67:35];
   assign q_times_ten = {1'b0, q_est, 3'b000} + {3'b000, q_est, 1'b0};
   assign div_diff    = {1'b0, div_num} - q_times_ten;

   always_comb begin
      if (div_diff[36]) begin
         div_quot = 32'(q_est - 33'd1);
         div_rem  = 4'(div_diff + 37'd10);
      end else begin
         div_quot = q_est[31:0];
         div_rem  = div_diff[3:0];
      end
   end

   // Half-to-even on the last removed digit only.
   assign round_up  = (rem_ff > 4'd5) || ((rem_ff == 4'd5) && value_ff[0]);
   assign value_inc = value_ff + WideWidth'(round_up);
   assign scale_dec = scale_ff - ScaleWidth'(1);
   assign value_big = |value_ff[WideWidth-1:NarrowWidth];
   assign inc_big   = |value_inc[WideWidth-1:NarrowWidth];

   always_comb begin
      state_in     = state_ff;
      value_in     = value_ff;
      saved_in     = saved_ff;
      scale_in     = scale_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      // Drop the response once the consumer takes it.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               value_in = {req_data.upper_high, req_data.upper_low,
                           req_data.lower_high, req_data.lower_low};
               saved_in = {req_data.lower_high, req_data.lower_low};
               scale_in = req_data.scale_in;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            rem_in = '0;
            cnt_in = '0;
            if ((scale_ff != '0) && value_big) begin
               state_in = ST_DIV;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_DIV: begin
            // Rotate: the quotient limb enters at the bottom, so once all six limbs
            // have passed through, the limbs are back in place.
            value_in = {value_ff[WideWidth-LimbWidth-1:0], div_quot};
            rem_in   = div_rem;
            cnt_in   = cnt_ff + CntWidth'(1);
            if (cnt_ff == LastLimb) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            value_in = value_inc;
            scale_in = scale_dec;
            rem_in   = '0;
            cnt_in   = '0;
            if ((scale_dec != '0) && inc_big) begin
               state_in = ST_DIV;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Hold until the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.too_large     = value_big;
               rsp_data_in.scale_out     = scale_ff;
               if (value_big) begin
                  rsp_data_in.mantissa_high = saved_ff[NarrowWidth-1:64];
                  rsp_data_in.mantissa_low  = saved_ff[63:0];
               end else begin
                  rsp_data_in.mantissa_high = value_ff[NarrowWidth-1:64];
                  rsp_data_in.mantissa_low  = value_ff[63:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      value_ff    <= value_in;
      saved_ff    <= saved_in;
      scale_ff    <= scale_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
